[rtl/mtcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_pkg: shared types and constants for the threshold crossing scan
// Item, result and cell-to-cell record formats, mode and register codes.
// ----------------------------------------------------------------------------
package mtcs_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int MIN_W       = 16;
	localparam int STEP_W      = 12;
	localparam int TCOUNT_W    = 9;
	localparam int WIN_W       = 10;
	localparam int IDX_W       = 8;
	localparam int COUNT_W     = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [1:0] {
		MODE_SAMPLE = 2'd0,
		MODE_READ   = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_RSVD   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD_MIN   = 3'd0,
		REG_THRESHOLD_STEP  = 3'd1,
		REG_THRESHOLD_COUNT = 3'd2,
		REG_WINDOW_FIRST    = 3'd3,
		REG_WINDOW_LAST     = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_ARMED = 2'd1,
		PH_FIRED = 2'd2
	} phase_t;

	typedef struct packed {
		mode_t                         mode;
		logic signed [SAMPLE_BITS-1:0] sample_value;
		logic                          event_end;
		logic [IDX_W-1:0]              read_index;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count_value;
		logic [IDX_W-1:0]   count_index;
	} result_t;

	// Record handed from one cell to the next.
	typedef struct packed {
		logic                          valid;
		mode_t                         op;
		logic                          last;
		logic                          inwin;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [STEP_W-1:0]             step;
		logic [IDX_W-1:0]              rd_idx;
		logic [COUNT_W-1:0]            rd_cnt;
	} link_t;

endpackage

[rtl/mtcs_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_cell: one threshold cell of the scan chain
// Holds the phase and event count of one threshold and passes each request on.
// ----------------------------------------------------------------------------
module mtcs_cell
	import mtcs_pkg::*;
#(
	parameter int IDX   = 0,
	parameter int CMP_W = 26,
	parameter int REM_W = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    advance,
	input  link_t                   prev_item,
	input  logic signed [CMP_W-1:0] prev_thr,
	input  logic [REM_W-1:0]        prev_rem,
	output link_t                   next_item,
	output logic signed [CMP_W-1:0] next_thr,
	output logic [REM_W-1:0]        next_rem
);

	phase_t             phase_q;
	phase_t             ph_next;
	logic [COUNT_W-1:0] count_q;
	logic               active;
	logic               thr_pos;
	logic               idx_hit;
	logic signed [CMP_W-1:0] s_ext;
	logic signed [CMP_W-1:0] s2_ext;
	link_t              item_out;

	// The remaining grid size travels with the request; zero means this cell is unused.
	assign active  = (prev_rem != '0);
	assign thr_pos = !prev_thr[CMP_W-1] && (prev_thr != '0);
	assign idx_hit = (32'(prev_item.rd_idx) == 32'(IDX));
	assign s_ext   = CMP_W'(prev_item.sample);
	assign s2_ext  = s_ext <<< 1;

	always_comb begin
		ph_next = phase_q;
		if (active && prev_item.inwin) begin
			if (thr_pos) begin
				case (phase_q)
					PH_IDLE: begin
						if (s2_ext < prev_thr) ph_next = PH_ARMED;
					end
					PH_ARMED: begin
						if (s_ext > prev_thr) ph_next = PH_FIRED;
					end
					default: ;
				endcase
			end else if (s_ext < prev_thr) begin
				ph_next = PH_FIRED;
			end
		end
	end

	// A read request picks up this cell's count when the index matches.
	always_comb begin
		item_out = prev_item;
		if (prev_item.valid && prev_item.op == MODE_READ && active && idx_hit) begin
			item_out.rd_cnt = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			count_q   <= '0;
			next_item <= '0;
		end else if (advance) begin
			next_item <= item_out;
			if (prev_item.valid) begin
				case (prev_item.op)
					MODE_SAMPLE: begin
						if (prev_item.last) begin
							phase_q <= PH_IDLE;
							if (active && ph_next == PH_FIRED && count_q != '1) begin
								count_q <= count_q + COUNT_W'(1);
							end
						end else begin
							phase_q <= ph_next;
						end
					end
					MODE_CLEAR: begin
						count_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			next_thr <= prev_thr + CMP_W'(prev_item.step);
			next_rem <= active ? prev_rem - REM_W'(1) : prev_rem;
		end
	end

endmodule

[rtl/mtcs_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtcs_front: configuration registers and request entry of the scan chain
// Tracks the sample position within an event and builds the head record.
// ----------------------------------------------------------------------------
module mtcs_front
	import mtcs_pkg::*;
#(
	parameter int MAX_THRESHOLDS    = 256,
	parameter int SAMPLES_PER_EVENT = 1024,
	parameter int CMP_W             = 26,
	parameter int REM_W             = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    accept,
	input  item_t                   item,
	output link_t                   head_item,
	output logic signed [CMP_W-1:0] head_thr,
	output logic [REM_W-1:0]        head_rem
);

	localparam int POS_W  = $clog2(SAMPLES_PER_EVENT);
	localparam int WCMP_W = (POS_W > WIN_W) ? POS_W : WIN_W;

	logic signed [MIN_W-1:0] thr_min_q;
	logic [STEP_W-1:0]       thr_step_q;
	logic [TCOUNT_W-1:0]     thr_count_q;
	logic [WIN_W-1:0]        win_first_q;
	logic [WIN_W-1:0]        win_last_q;
	logic [POS_W-1:0]        pos_q;
	logic [WCMP_W-1:0]       pos_ext;
	logic                    inwin;
	logic [31:0]             grid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_min_q   <= '0;
			thr_step_q  <= STEP_W'(1);
			thr_count_q <= TCOUNT_W'(256);
			win_first_q <= '0;
			win_last_q  <= '1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_THRESHOLD_MIN:   thr_min_q   <= cfg_data[MIN_W-1:0];
				REG_THRESHOLD_STEP:  thr_step_q  <= cfg_data[STEP_W-1:0];
				REG_THRESHOLD_COUNT: thr_count_q <= cfg_data[TCOUNT_W-1:0];
				REG_WINDOW_FIRST:    win_first_q <= cfg_data[WIN_W-1:0];
				REG_WINDOW_LAST:     win_last_q  <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept && item.mode == MODE_SAMPLE) begin
			if (item.event_end || pos_q == POS_W'(SAMPLES_PER_EVENT - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	assign pos_ext = WCMP_W'(pos_q);
	assign inwin   = (pos_ext >= WCMP_W'(win_first_q)) && (pos_ext <= WCMP_W'(win_last_q));
	assign grid    = (32'(thr_count_q) < 32'(MAX_THRESHOLDS)) ? 32'(thr_count_q)
	                                                         : 32'(MAX_THRESHOLDS);

	always_comb begin
		head_item.valid  = accept && (item.mode != MODE_RSVD);
		head_item.op     = item.mode;
		head_item.last   = item.event_end;
		head_item.inwin  = inwin;
		head_item.sample = item.sample_value;
		head_item.step   = thr_step_q;
		head_item.rd_idx = item.read_index;
		head_item.rd_cnt = '0;
	end

	assign head_thr = CMP_W'(thr_min_q);
	assign head_rem = REM_W'(grid);

endmodule

[rtl/multi_threshold_crossing_scan_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_threshold_crossing_scan_core: discriminator threshold scan counter bank
// A chain of threshold cells counts, per threshold, the events that crossed it.
// ----------------------------------------------------------------------------
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+------------------------------
//   item     | in        | item_valid/item_stall  | mode, sample, event end, index
//   result   | out       | result_valid/stall     | count value and index
//   cfg      | in        | cfg_valid/cfg_ready    | register index and data
//
// One request enters per cycle unless the chain is stalled; it walks the chain one cell
// per advancing cycle, and a read result is registered after the last cell.
// Sample and clear requests leave no result and are done once they leave the last cell.
// A held result stalls the whole chain, and item_stall follows it.
// Reset clears all counts and phases at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_threshold_crossing_scan_core
	import mtcs_pkg::*;
#(
	parameter int MAX_THRESHOLDS    = 256,
	parameter int SAMPLES_PER_EVENT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int THR_W = 18 + $clog2(MAX_THRESHOLDS);
	localparam int CMP_W = (THR_W > SAMPLE_BITS + 2) ? THR_W : SAMPLE_BITS + 2;
	localparam int REM_W = $clog2(MAX_THRESHOLDS + 1);

	link_t                   link_item [MAX_THRESHOLDS+1];
	logic signed [CMP_W-1:0] link_thr  [MAX_THRESHOLDS+1];
	logic [REM_W-1:0]        link_rem  [MAX_THRESHOLDS+1];
	logic                    advance;
	logic                    accept;
	logic                    result_valid_q;
	result_t                 result_q;
	link_t                   tail;

	assign cfg_ready    = 1'b1;
	assign advance      = !result_valid_q || !result_stall;
	assign item_stall   = !advance;
	assign accept       = item_valid && advance;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign tail         = link_item[MAX_THRESHOLDS];

	mtcs_front #(
		.MAX_THRESHOLDS    (MAX_THRESHOLDS),
		.SAMPLES_PER_EVENT (SAMPLES_PER_EVENT),
		.CMP_W             (CMP_W),
		.REM_W             (REM_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.item      (item),
		.head_item (link_item[0]),
		.head_thr  (link_thr[0]),
		.head_rem  (link_rem[0])
	);

	for (genvar k = 0; k < MAX_THRESHOLDS; k++) begin : g_cell
		mtcs_cell #(
			.IDX   (k),
			.CMP_W (CMP_W),
			.REM_W (REM_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.prev_item (link_item[k]),
			.prev_thr  (link_thr[k]),
			.prev_rem  (link_rem[k]),
			.next_item (link_item[k+1]),
			.next_thr  (link_thr[k+1]),
			.next_rem  (link_rem[k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= tail.valid && (tail.op == MODE_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tail.valid && tail.op == MODE_READ) begin
			result_q.count_value <= tail.rd_cnt;
			result_q.count_index <= tail.rd_idx;
		end
	end

`ifndef ASSERT_OFF
	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid)
		else $error("item stall raised with no result pending");

	a_reserved_mode_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.mode == MODE_RSVD) |=> !link_item[1].valid)
		else $error("reserved mode request entered the chain");

	a_tail_thr_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!advance && !$isunknown(link_thr[MAX_THRESHOLDS])) |=>
			($stable(link_thr[MAX_THRESHOLDS]) && $stable(link_rem[MAX_THRESHOLDS])))
		else $error("chain moved while stalled");
`endif

endmodule

[dv/tb_multi_threshold_crossing_scan_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_multi_threshold_crossing_scan_core: self-checking bench for the scan core
// A queue-fed driver sends sample, read, clear and unused-mode requests. A
// cycle-free predictor keeps its own cells and counts. The monitor checks each
// read result in order, under random stalls and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_multi_threshold_crossing_scan_core;
	import mtcs_pkg::*;

	localparam int MAX_THRESHOLDS    = 256;
	localparam int SAMPLES_PER_EVENT = 1024;
	localparam int DRAIN_CYCLES      = MAX_THRESHOLDS + 16;
	localparam int HOLD_CYCLES       = 800;
	localparam int WATCHDOG_LIMIT    = 4000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_stall;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	// Mirror of the configuration and the scan state.
	int              thr_min   = 0;
	logic [11:0]     thr_step  = 12'd1;
	logic [8:0]      thr_count = 9'd256;
	logic [9:0]      win_first = 10'd0;
	logic [9:0]      win_last  = 10'd1023;
	phase_t          cell_state [MAX_THRESHOLDS];
	logic [31:0]     tally [MAX_THRESHOLDS];
	logic [9:0]      sample_pos = '0;

	item_t   pending_items [$];
	result_t expected_counts [$];
	int      items_queued = 0;
	int      fail_count   = 0;
	bit      idle_on      = 1'b1;
	bit      hold_req     = 1'b0;
	bit      hold_done    = 1'b0;
	int      gap_left     = 0;
	int      stall_left   = 0;
	int      hold_left    = 0;
	int      quiet        = 0;

	multi_threshold_crossing_scan_core #(
		.MAX_THRESHOLDS(MAX_THRESHOLDS),
		.SAMPLES_PER_EVENT(SAMPLES_PER_EVENT)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		for (int k = 0; k < MAX_THRESHOLDS; k++) begin
			cell_state[k] = PH_IDLE;
			tally[k] = '0;
		end
	end

	initial forever #10 clk = ~clk;

	function automatic int grid_size();
		return (thr_count < MAX_THRESHOLDS) ? int'(thr_count) : MAX_THRESHOLDS;
	endfunction

	// Advances the cells and counts by one accepted request.
	task automatic scan_predict(item_t r);
		int      grid;
		int      thr;
		int      s;
		int      k;
		result_t res;
		grid = grid_size();
		case (r.mode)
			MODE_READ: begin
				res.count_index = r.read_index;
				res.count_value = (int'(r.read_index) < grid) ? tally[r.read_index] : '0;
				expected_counts = {expected_counts, res};
			end
			MODE_CLEAR: begin
				for (k = 0; k < MAX_THRESHOLDS; k++) tally[k] = '0;
			end
			MODE_SAMPLE: begin
				s = int'($signed(r.sample_value));
				if (sample_pos >= win_first && sample_pos <= win_last) begin
					for (k = 0; k < grid; k++) begin
						thr = thr_min + k * int'(thr_step);
						// A positive threshold needs a dip below half of it first.
						if (thr > 0) begin
							if (cell_state[k] == PH_IDLE) begin
								if (2 * s < thr) cell_state[k] = PH_ARMED;
							end else if (cell_state[k] == PH_ARMED) begin
								if (s > thr) cell_state[k] = PH_FIRED;
							end
						end else if (s < thr) begin
							cell_state[k] = PH_FIRED;
						end
					end
				end
				if (r.event_end) begin
					for (k = 0; k < grid; k++)
						if (cell_state[k] == PH_FIRED && tally[k] != '1) tally[k] = tally[k] + 1;
					for (k = 0; k < MAX_THRESHOLDS; k++) cell_state[k] = PH_IDLE;
					sample_pos = '0;
				end else begin
					sample_pos = sample_pos + 1'b1;
				end
			end
			default: ;
		endcase
	endtask

	// Driver: the payload only changes when the slot is empty or was just taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			gap_left <= 0;
		end else begin
			if (item_valid && !item_stall) scan_predict(item);
			if (!item_valid || !item_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					if (idle_on && $urandom_range(0, 7) == 0) begin
						gap_left <= $urandom_range(0, 5);
						item_valid <= 1'b0;
					end else begin
						item <= pending_items.pop_front();
						item_valid <= 1'b1;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks results in order and decides the stall pattern.
	always @(posedge clk or negedge arst_n) begin
		result_t exp_res;
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_counts.size() == 0) begin
					$error("unexpected result: count_index %0d count_value %0d",
						result.count_index, result.count_value);
					fail_count++;
				end else begin
					exp_res = expected_counts.pop_front();
					if (result.count_value !== exp_res.count_value) begin
						$error("count_value: expected %0d, actual %0d",
							exp_res.count_value, result.count_value);
						fail_count++;
					end
					if (result.count_index !== exp_res.count_index) begin
						$error("count_index: expected %0d, actual %0d",
							exp_res.count_index, result.count_index);
						fail_count++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				result_stall <= 1'b1;
			end else if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				result_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				result_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 5);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= WATCHDOG_LIMIT) begin
			$display("multi_threshold_crossing_scan_core: mismatch");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	function automatic logic [15:0] to_sample(int v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic logic [7:0] pick_index();
		int g;
		g = grid_size();
		if (g > 0 && $urandom_range(0, 4) != 0) return 8'($urandom_range(0, g - 1));
		return 8'($urandom);
	endfunction

	task automatic push_item(mode_t m, logic [15:0] s, bit e, logic [7:0] idx);
		item_t it;
		it.mode = m;
		it.sample_value = s;
		it.event_end = e;
		it.read_index = idx;
		pending_items = {pending_items, it};
		if (m != MODE_RSVD) items_queued++;
	endtask

	task automatic push_read(logic [7:0] idx);
		push_item(MODE_READ, 16'($urandom), 1'($urandom), idx);
	endtask

	// A quiet baseline with one pulse aimed into the threshold grid.
	task automatic push_event(bit close);
		int len;
		int at;
		int peak;
		int span;
		int v;
		int i;
		span = ((grid_size() > 0) ? grid_size() : 1) * int'(thr_step);
		len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 24);
		at = $urandom_range(1, len - 1);
		peak = thr_min + int'($urandom_range(0, span)) - int'($urandom_range(0, 64));
		for (i = 0; i < len; i++) begin
			if (i == at) v = peak;
			else if (i == at - 1 || i == at + 1) v = peak / 2;
			else v = int'($urandom_range(0, 64)) - 32;
			if ($urandom_range(0, 24) == 0)
				push_item(MODE_SAMPLE, 16'($urandom), close && i == len - 1, 8'($urandom));
			else
				push_item(MODE_SAMPLE, to_sample(v), close && i == len - 1, 8'($urandom));
		end
	endtask

	task automatic push_traffic(int n);
		int         goal;
		int         c;
		logic [7:0] idx;
		goal = items_queued + n;
		while (items_queued < goal) begin
			c = $urandom_range(0, 99);
			if (c < 60) begin
				push_event(1'b1);
				repeat ($urandom_range(0, 3)) push_read(pick_index());
			end else if (c < 75) begin
				repeat ($urandom_range(1, 8)) push_read(pick_index());
			end else if (c < 85) begin
				push_item(MODE_SAMPLE, 16'($urandom), 1'($urandom), 8'($urandom));
			end else if (c < 90) begin
				push_event(1'b0);
			end else if (c < 93) begin
				push_item(MODE_CLEAR, 16'($urandom), 1'($urandom), 8'($urandom));
			end else if (c < 96) begin
				push_item(MODE_RSVD, 16'($urandom), 1'($urandom), 8'($urandom));
			end else begin
				idx = pick_index();
				repeat (8) begin
					push_read(idx);
					idx = idx + 1'b1;
				end
			end
		end
		// Sometimes leave an event open across the next register write.
		if ($urandom_range(0, 1) == 0) push_event(1'b0);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_counts.size() != 0);
		// Sample and clear requests can still be walking the chain.
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [15:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (r)
			REG_THRESHOLD_MIN:   thr_min = int'($signed(d));
			REG_THRESHOLD_STEP:  thr_step = d[11:0];
			REG_THRESHOLD_COUNT: thr_count = d[8:0];
			REG_WINDOW_FIRST:    win_first = d[9:0];
			REG_WINDOW_LAST:     win_last = d[9:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(int mn, int st, int cnt, int wf, int wl);
		write_reg(REG_THRESHOLD_MIN, 16'(mn));
		write_reg(REG_THRESHOLD_STEP, 16'(st));
		write_reg(REG_THRESHOLD_COUNT, 16'(cnt));
		write_reg(REG_WINDOW_FIRST, 16'(wf));
		write_reg(REG_WINDOW_LAST, 16'(wl));
	endtask

	task automatic random_config();
		int mn;
		int st;
		int cnt;
		int wf;
		int wl;
		int c;
		if ($urandom_range(0, 9) == 0) mn = int'($signed(16'($urandom)));
		else mn = int'($urandom_range(0, 6000)) - 3000;
		c = $urandom_range(0, 19);
		if (c == 0) st = 0;
		else if (c == 1) st = 4095;
		else st = $urandom_range(1, 200);
		c = $urandom_range(0, 19);
		if (c == 0) cnt = 0;
		else if (c == 1) cnt = $urandom_range(257, 511);
		else cnt = $urandom_range(1, 256);
		wf = $urandom_range(0, 12);
		c = $urandom_range(0, 9);
		if (c == 0 && wf > 0) wl = $urandom_range(0, wf - 1);
		else if (c < 3) wl = 1023;
		else wl = $urandom_range(wf, 40);
		set_config(mn, st, cnt, wf, wl);
	endtask

	initial begin
		int ph;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: thresholds 0..255, full window.
		push_item(MODE_SAMPLE, 16'h0000, 1'b0, 8'hFF);
		push_item(MODE_SAMPLE, 16'h8000, 1'b0, 8'h00);
		push_item(MODE_SAMPLE, 16'h7FFF, 1'b1, 8'h5A);
		push_item(MODE_RSVD, 16'($urandom), 1'b1, 8'($urandom));
		push_read(8'd0);
		push_read(8'd255);
		push_read(8'd127);
		push_item(MODE_SAMPLE, 16'd100, 1'b0, 8'h00);
		push_item(MODE_SAMPLE, 16'd0, 1'b0, 8'h00);
		push_item(MODE_SAMPLE, 16'd50, 1'b1, 8'h00);
		push_read(8'd49);
		push_read(8'd50);
		push_item(MODE_CLEAR, 16'hFFFF, 1'b1, 8'hFF);
		push_read(8'd0);
		push_item(MODE_SAMPLE, 16'h5555, 1'b1, 8'hAA);
		push_item(MODE_SAMPLE, 16'hAAAA, 1'b1, 8'h55);
		push_read(8'hAA);
		push_read(8'h55);
		wait_drained();

		// No cells in use and an empty window.
		set_config(-32768, 4095, 0, 1023, 0);
		push_item(MODE_SAMPLE, 16'h8000, 1'b0, 8'h00);
		push_item(MODE_SAMPLE, 16'h7FFF, 1'b1, 8'h00);
		push_read(8'd0);
		push_read(8'd255);
		wait_drained();

		// Zero step with a count above the grid: 256 cells all at -5.
		set_config(-5, 0, 300, 0, 1023);
		push_item(MODE_SAMPLE, 16'hFFFA, 1'b1, 8'h00);
		push_read(8'd255);
		push_read(8'd0);
		wait_drained();

		// Narrow window and an event long enough for the position to wrap.
		set_config(-100, 3, 200, 2, 6);
		repeat (SAMPLES_PER_EVENT + 5) push_item(MODE_SAMPLE, 16'($urandom), 1'b0, 8'h00);
		push_item(MODE_SAMPLE, 16'($urandom), 1'b1, 8'h00);
		push_read(8'd0);
		push_read(8'd100);
		push_read(8'd199);
		push_read(8'd200);
		wait_drained();

		// Armed cells whose threshold turns negative in the middle of an event.
		set_config(-50, 10, 32, 0, 1023);
		push_item(MODE_SAMPLE, to_sample(-1000), 1'b0, 8'h00);
		wait_drained();
		set_config(-500, 10, 32, 0, 1023);
		push_item(MODE_SAMPLE, to_sample(-300), 1'b1, 8'h00);
		push_read(8'd0);
		push_read(8'd10);
		push_read(8'd31);
		push_read(8'd40);

		for (ph = 0; ph < 8; ph++) begin
			wait_drained();
			random_config();
			if (ph == 7) idle_on = 1'b0;
			if (ph == 2) begin
				// Hold the result side long enough for the chain to back up.
				hold_req = 1'b1;
				push_traffic(20);
				repeat (250) push_read(pick_index());
				push_traffic(20);
			end else begin
				push_traffic(40);
			end
		end
		wait_drained();

		if (fail_count == 0) begin
			$display("multi_threshold_crossing_scan_core: match");
		end else begin
			$display("multi_threshold_crossing_scan_core: mismatch");
		end
		$finish;
	end

endmodule

[multi_threshold_crossing_scan_core.f]
rtl/mtcs_pkg.sv
rtl/mtcs_cell.sv
rtl/mtcs_front.sv
rtl/multi_threshold_crossing_scan_core.sv
dv/tb_multi_threshold_crossing_scan_core.sv
